@@ design/stq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer queue package
// Shared widths, codes and the slot entry layout of the timer queue.
// ----------------------------------------------------------------------------
package stq_pkg;

    localparam int MODE_W     = 2;
    localparam int INTERVAL_W = 24;
    localparam int SLOT_W     = 4;
    localparam int TIME_W     = 32;
    localparam int STATUS_W   = 2;

    localparam logic [MODE_W-1:0] MODE_START = 2'd0;
    localparam logic [MODE_W-1:0] MODE_STOP  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TICK  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_TIMER = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NONE_DUE = 2'd3;

    typedef struct packed {
        logic [TIME_W-1:0]     deadline;
        logic [INTERVAL_W-1:0] period;
        logic                  repeat_flag;
    } t_entry;

    typedef struct packed {
        logic [TIME_W-1:0] sum;
        logic              neg;
        logic              zero;
    } t_alu_res;

endpackage

@@ design/stq_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer queue channels
// Request and response channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface stq_req_if;
    import stq_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [MODE_W-1:0]     mode;
    logic [INTERVAL_W-1:0] interval_ms;
    logic                  periodic;
    logic [SLOT_W-1:0]     slot_id;
    logic [TIME_W-1:0]     now_ms;

    modport source (output valid, mode, interval_ms, periodic, slot_id, now_ms,
                    input ready);
    modport sink (input valid, mode, interval_ms, periodic, slot_id, now_ms,
                  output ready);
endinterface

interface stq_rsp_if;
    import stq_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   result_id;
    logic                fired;

    modport source (output valid, status, result_id, fired, input ready);
    modport sink (input valid, status, result_id, fired, output ready);
endinterface

@@ design/stq_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module stq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ design/stq_alu.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer queue arithmetic unit
// Shared 32-bit adder and subtractor with sign and zero flags.
// ----------------------------------------------------------------------------
module stq_alu (
    input  logic [stq_pkg::TIME_W-1:0] i_a,
    input  logic [stq_pkg::TIME_W-1:0] i_b,
    input  logic                       i_sub,
    output stq_pkg::t_alu_res          o_res
);
    import stq_pkg::*;

    logic [TIME_W-1:0] sum;

    assign sum        = i_sub ? (i_a - i_b) : (i_a + i_b);
    assign o_res.sum  = sum;
    assign o_res.neg  = sum[TIME_W-1];
    assign o_res.zero = (sum == '0);
endmodule

@@ design/software_timer_queue_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Software timer queue core
// Table of one-shot and periodic timers served by a small sequencer.
// ----------------------------------------------------------------------------
// The block holds MAX_TIMERS timer slots and takes one request item at a
// time. An item with the unused mode goes straight to the push step. A stop
// item checks its slot in the stop step before the push step. A start item
// scans the live bits one slot per cycle and takes the lowest free slot, or
// reports a full table when no slot is free. A tick item reads every slot's
// deadline from the slot RAM, one address per cycle, and compares it in the
// shared 32-bit subtractor. A check step follows, then a reload step when a
// periodic timer fires and is reloaded, then the push step. The single RAM
// read port and the one arithmetic unit make both scans go one slot at a
// time. The input is not ready until the response of the current item has
// been placed in the output register, so a response that waits to be taken
// holds the next item in its push step until it is taken.
module software_timer_queue_core #(
    parameter int MAX_TIMERS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    stq_req_if.sink    i_req,
    stq_rsp_if.source  o_rsp
);
    import stq_pkg::*;

    localparam int AW = $clog2(MAX_TIMERS);
    localparam int CW = $clog2(MAX_TIMERS + 1);
    localparam logic [CW-1:0] END_IDX = CW'(MAX_TIMERS);
    localparam int EW = $bits(t_entry);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_FREE   = 7'b0000010,
        S_STOP   = 7'b0000100,
        S_TSCAN  = 7'b0001000,
        S_TCHK   = 7'b0010000,
        S_RELOAD = 7'b0100000,
        S_PUSH   = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    logic [MODE_W-1:0]     r_mode;
    logic [INTERVAL_W-1:0] r_interval;
    logic                  r_periodic;
    logic [SLOT_W-1:0]     r_slot;
    logic [TIME_W-1:0]     r_now;

    logic [MAX_TIMERS-1:0] r_live;
    logic [CW-1:0]         r_idx;
    logic                  r_pv;
    logic [AW-1:0]         r_pidx;
    logic                  r_found;
    logic [AW-1:0]         r_best;
    t_entry                r_best_ent;

    logic [STATUS_W-1:0] r_status;
    logic [SLOT_W-1:0]   r_id;
    logic                r_fired;

    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [SLOT_W-1:0]   r_out_id;
    logic                r_out_fired;

    logic [TIME_W-1:0] alu_a;
    logic [TIME_W-1:0] alu_b;
    logic              alu_sub;
    t_alu_res          alu;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    t_entry        ram_wdata;
    logic [EW-1:0] ram_rdata;
    t_entry        rd_ent;

    logic [AW-1:0] scan_idx;
    logic          scan_end;
    logic          free_hit;
    logic [AW-1:0] stop_idx;
    logic          stop_ok;
    logic          fire;
    logic          accept;
    logic          push;

    assign scan_idx = r_idx[AW-1:0];
    assign scan_end = (r_idx == END_IDX);
    assign free_hit = !scan_end && !r_live[scan_idx];
    assign stop_idx = AW'(r_slot);
    assign stop_ok  = (32'(r_slot) < MAX_TIMERS) && r_live[stop_idx];
    assign fire     = r_found && !alu.zero && !alu.neg;
    assign accept   = i_req.valid && i_req.ready;
    assign push     = (r_state == S_PUSH) && (!r_out_valid || o_rsp.ready);
    assign rd_ent   = t_entry'(ram_rdata);

    assign i_req.ready     = (r_state == S_IDLE);
    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.status    = r_out_status;
    assign o_rsp.result_id = r_out_id;
    assign o_rsp.fired     = r_out_fired;

    stq_alu u_alu (
        .i_a   (alu_a),
        .i_b   (alu_b),
        .i_sub (alu_sub),
        .o_res (alu)
    );

    stq_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_TIMERS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (scan_idx),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        alu_a     = r_now;
        alu_b     = {{(TIME_W - INTERVAL_W){1'b0}}, r_interval};
        alu_sub   = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = scan_idx;
        ram_wdata = '{deadline: alu.sum, period: r_interval, repeat_flag: r_periodic};
        unique case (r_state)
            S_FREE: begin
                ram_we = free_hit;
            end
            S_TSCAN: begin
                alu_a   = rd_ent.deadline;
                alu_b   = r_best_ent.deadline;
                alu_sub = 1'b1;
            end
            S_TCHK: begin
                alu_b   = r_best_ent.deadline;
                alu_sub = 1'b1;
            end
            S_RELOAD: begin
                alu_b     = {{(TIME_W - INTERVAL_W){1'b0}}, r_best_ent.period};
                ram_we    = 1'b1;
                ram_waddr = r_best;
                ram_wdata = '{deadline: alu.sum, period: r_best_ent.period,
                              repeat_flag: r_best_ent.repeat_flag};
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    unique case (i_req.mode)
                        MODE_START: n_state = S_FREE;
                        MODE_STOP:  n_state = S_STOP;
                        MODE_TICK:  n_state = S_TSCAN;
                        default:    n_state = S_PUSH;
                    endcase
                end
            end
            S_FREE: begin
                if (scan_end || !r_live[scan_idx]) begin
                    n_state = S_PUSH;
                end
            end
            S_STOP: n_state = S_PUSH;
            S_TSCAN: begin
                if (scan_end && !r_pv) begin
                    n_state = S_TCHK;
                end
            end
            S_TCHK: begin
                n_state = (fire && r_best_ent.repeat_flag) ? S_RELOAD : S_PUSH;
            end
            S_RELOAD: n_state = S_PUSH;
            S_PUSH: begin
                if (push) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_live      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (push) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            if ((r_state == S_FREE) && free_hit) begin
                r_live[scan_idx] <= 1'b1;
            end
            if ((r_state == S_STOP) && stop_ok) begin
                r_live[stop_idx] <= 1'b0;
            end
            if ((r_state == S_TCHK) && fire && !r_best_ent.repeat_flag) begin
                r_live[r_best] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_mode     <= i_req.mode;
                    r_interval <= i_req.interval_ms;
                    r_periodic <= i_req.periodic;
                    r_slot     <= i_req.slot_id;
                    r_now      <= i_req.now_ms;
                    r_idx      <= '0;
                    r_pv       <= 1'b0;
                    r_found    <= 1'b0;
                    r_status   <= ST_NONE_DUE;
                    r_id       <= '0;
                    r_fired    <= 1'b0;
                end
            end
            S_FREE: begin
                if (scan_end) begin
                    r_status <= ST_FULL;
                    r_id     <= '0;
                end else if (!r_live[scan_idx]) begin
                    r_status <= ST_OK;
                    r_id     <= SLOT_W'(scan_idx);
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            S_STOP: begin
                if (stop_ok) begin
                    r_status <= ST_OK;
                    r_id     <= r_slot;
                end else begin
                    r_status <= ST_NO_TIMER;
                    r_id     <= '0;
                end
            end
            S_TSCAN: begin
                if (!scan_end) begin
                    r_pv   <= r_live[scan_idx];
                    r_pidx <= scan_idx;
                    r_idx  <= r_idx + 1'b1;
                end else begin
                    r_pv <= 1'b0;
                end
                if (r_pv && (!r_found || alu.neg)) begin
                    r_found    <= 1'b1;
                    r_best     <= r_pidx;
                    r_best_ent <= rd_ent;
                end
            end
            S_TCHK: begin
                if (fire) begin
                    r_status <= ST_OK;
                    r_id     <= SLOT_W'(r_best);
                    r_fired  <= 1'b1;
                end
            end
            S_PUSH: begin
                if (push) begin
                    r_out_status <= (r_mode == MODE_START || r_mode == MODE_STOP ||
                                     r_mode == MODE_TICK) ? r_status : ST_NONE_DUE;
                    r_out_id     <= r_id;
                    r_out_fired  <= r_fired;
                end
            end
            default: begin
            end
        endcase
    end
endmodule
